/* hw/rtl/hsv2rgb_pkg.sv */
// ============================================================================
// hsv2rgb_pkg
// Shared widths, constants and types of the HSV to RGB converter.
// ============================================================================
package hsv2rgb_pkg;

  // payload widths of the two channels
  localparam int HUE_W = 17;
  localparam int SV_W  = 14;
  localparam int OUT_W = 13;

  // default number of fraction bits of saturation, value and the components
  localparam int FRAC_BITS_DEF = 12;

  // hue constants in hundredths of a degree
  localparam int HUE_TURN   = 36000;
  localparam int HUE_MAX    = 35990;
  localparam int HUE_SECTOR = 6000;
  localparam int HUE_NSEC   = 6;

  // width of the wrapped and clamped hue and of the remainder within a sector
  localparam int H_W   = 16;
  localparam int REM_W = 13;

  // color wheel sector, named by the hues at its two ends
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

/* hw/rtl/hsv_in_if.sv */
// ============================================================================
// hsv_in_if
// Request channel carrying one HSV color: hue, saturation and value.
// ============================================================================
interface hsv_in_if;

  logic                                 valid;
  logic                                 ready;
  logic signed [hsv2rgb_pkg::HUE_W-1:0] hue_centideg;
  logic signed [hsv2rgb_pkg::SV_W-1:0]  sat_q12;
  logic signed [hsv2rgb_pkg::SV_W-1:0]  val_q12;

  modport source (
    output valid, hue_centideg, sat_q12, val_q12,
    input  ready
  );

  modport sink (
    input  valid, hue_centideg, sat_q12, val_q12,
    output ready
  );

endinterface

/* hw/rtl/rgb_out_if.sv */
// ============================================================================
// rgb_out_if
// Result channel carrying one RGB color in unsigned fixed point.
// ============================================================================
interface rgb_out_if;

  logic                              valid;
  logic                              ready;
  logic [hsv2rgb_pkg::OUT_W-1:0]     red_q12;
  logic [hsv2rgb_pkg::OUT_W-1:0]     green_q12;
  logic [hsv2rgb_pkg::OUT_W-1:0]     blue_q12;

  modport source (
    output valid, red_q12, green_q12, blue_q12,
    input  ready
  );

  modport sink (
    input  valid, red_q12, green_q12, blue_q12,
    output ready
  );

endinterface

/* hw/rtl/hsv_to_rgb_converter_core.sv */
// ============================================================================
// hsv_to_rgb_converter_core
// Fixed-point HSV to RGB, seven-stage pipeline, one color a clock unless stalled.
// ============================================================================
// Converts one HSV color per request into red, green and blue with FRAC_BITS
// fraction bits. Hue is wrapped by one turn and clamped to 0..359.90 degrees,
// saturation and value are clamped to 0..1. The datapath is seven register
// stages deep, and a new request is taken every cycle while the output is
// not stalled. Each stage carries its own valid bit and moves when the stage
// after it is empty or moving, so a stalled output lets the earlier stages
// close up their bubbles; the longest path is one multiplier of up to 13 by
// 13 bits (or the sector divide-by-6000 correction) per stage.
module hsv_to_rgb_converter_core #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hsv_in_if.sink      in_ch,
  rgb_out_if.source   out_ch
);

  // derived widths and constants
  localparam int W      = FRAC_BITS + 1;
  localparam int CMP_W  = (hsv2rgb_pkg::SV_W > W) ? hsv2rgb_pkg::SV_W + 1 : W + 1;
  localparam int HX_W   = hsv2rgb_pkg::HUE_W + 1;
  localparam int NSTG   = 7;
  localparam int RCP_SH = 13;
  localparam longint unsigned RECIP =
    (64'd1 << (RCP_SH + FRAC_BITS)) / hsv2rgb_pkg::HUE_SECTOR;
  localparam int RCP_W  = $clog2(RECIP + 1);
  localparam int EP_W   = hsv2rgb_pkg::REM_W + RCP_W;
  localparam int NUM_W  = hsv2rgb_pkg::REM_W + FRAC_BITS;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage valid bits and per-stage load enables
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  // stage 1: wrapped hue, clamped saturation and value
  logic [hsv2rgb_pkg::H_W-1:0]     h1_r, h1_nxt;
  logic [W-1:0]                    s1_r, s1_nxt;
  logic [W-1:0]                    v1_r, v1_nxt;
  // stage 2: sector, remainder, p
  hsv2rgb_pkg::sector_t            sec2_r, sec2_nxt;
  logic [hsv2rgb_pkg::REM_W-1:0]   rem2_r, rem2_nxt;
  logic [W-1:0]                    s2_r, v2_r, p2_r, p2_nxt;
  // stage 3: estimate of f
  logic [FRAC_BITS-1:0]            est3_r, est3_nxt;
  logic [hsv2rgb_pkg::REM_W-1:0]   rem3_r;
  hsv2rgb_pkg::sector_t            sec3_r;
  logic [W-1:0]                    s3_r, v3_r, p3_r;
  // stage 4: exact f
  logic [FRAC_BITS-1:0]            f4_r, f4_nxt;
  hsv2rgb_pkg::sector_t            sec4_r;
  logic [W-1:0]                    s4_r, v4_r, p4_r;
  // stage 5: one minus the saturation terms of q and t
  logic [W-1:0]                    oq5_r, oq5_nxt, ot5_r, ot5_nxt;
  hsv2rgb_pkg::sector_t            sec5_r;
  logic [W-1:0]                    v5_r, p5_r;
  // stage 6: q and t
  logic [W-1:0]                    q6_r, q6_nxt, t6_r, t6_nxt;
  hsv2rgb_pkg::sector_t            sec6_r;
  logic [W-1:0]                    v6_r, p6_r;
  // stage 7: output register
  logic [hsv2rgb_pkg::OUT_W-1:0]   red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  // combinational intermediates
  logic signed [HX_W-1:0]          hue_x;
  logic signed [HX_W-1:0]          hue_w;
  logic signed [CMP_W-1:0]         sat_x, val_x;
  logic [2:0]                      sec_n;
  logic [hsv2rgb_pkg::H_W-1:0]     sec_base;
  logic [W-1:0]                    oms;
  logic [2*W-1:0]                  p_prod;
  logic [EP_W-1:0]                 est_prod;
  logic [NUM_W-1:0]                num, dp, diff;
  logic [W-1:0]                    omf;
  logic [2*W-1:0]                  sf_prod, s1f_prod;
  logic [2*W-1:0]                  q_prod, t_prod;

  // handshake: a stage loads when it is empty or its successor loads
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = in_ch.valid;
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  assign in_ch.ready = en[0];

  // stage 1: hue wrap and clamp, saturation and value clamp
  always_comb begin
    hue_x = {in_ch.hue_centideg[hsv2rgb_pkg::HUE_W-1], in_ch.hue_centideg};
    if (hue_x > $signed(HX_W'(hsv2rgb_pkg::HUE_TURN))) begin
      hue_w = hue_x - $signed(HX_W'(hsv2rgb_pkg::HUE_TURN));
    end else if (hue_x < 0) begin
      hue_w = hue_x + $signed(HX_W'(hsv2rgb_pkg::HUE_TURN));
    end else begin
      hue_w = hue_x;
    end
    if (hue_w < 0) begin
      h1_nxt = '0;
    end else if (hue_w > $signed(HX_W'(hsv2rgb_pkg::HUE_MAX))) begin
      h1_nxt = hsv2rgb_pkg::H_W'(hsv2rgb_pkg::HUE_MAX);
    end else begin
      h1_nxt = hue_w[hsv2rgb_pkg::H_W-1:0];
    end

    sat_x = {{(CMP_W - hsv2rgb_pkg::SV_W){in_ch.sat_q12[hsv2rgb_pkg::SV_W-1]}}, in_ch.sat_q12};
    val_x = {{(CMP_W - hsv2rgb_pkg::SV_W){in_ch.val_q12[hsv2rgb_pkg::SV_W-1]}}, in_ch.val_q12};
    if (sat_x < 0) begin
      s1_nxt = '0;
    end else if (sat_x > $signed(CMP_W'(ONE))) begin
      s1_nxt = ONE;
    end else begin
      s1_nxt = sat_x[W-1:0];
    end
    if (val_x < 0) begin
      v1_nxt = '0;
    end else if (val_x > $signed(CMP_W'(ONE))) begin
      v1_nxt = ONE;
    end else begin
      v1_nxt = val_x[W-1:0];
    end
  end

  // stage 2: sector by parallel compares, remainder, p = v * (1 - s)
  always_comb begin
    sec_n    = '0;
    sec_base = '0;
    for (int k = 1; k < hsv2rgb_pkg::HUE_NSEC; k++) begin
      if (h1_r >= hsv2rgb_pkg::H_W'(k * hsv2rgb_pkg::HUE_SECTOR)) begin
        sec_n    = 3'(k);
        sec_base = hsv2rgb_pkg::H_W'(k * hsv2rgb_pkg::HUE_SECTOR);
      end
    end
    sec2_nxt = hsv2rgb_pkg::sector_t'(sec_n);
    rem2_nxt = hsv2rgb_pkg::REM_W'(h1_r - sec_base);
    oms      = ONE - s1_r;
    p_prod   = (2*W)'(v1_r) * (2*W)'(oms);
    p2_nxt   = p_prod[FRAC_BITS +: W];
  end

  // stage 3: f estimate by reciprocal multiply, at most one below the true value
  always_comb begin
    est_prod = EP_W'(rem2_r) * EP_W'(RCP_W'(RECIP));
    est3_nxt = est_prod[RCP_SH +: FRAC_BITS];
  end

  // stage 4: correct the estimate with one compare and subtract
  always_comb begin
    num  = {rem3_r, {FRAC_BITS{1'b0}}};
    dp   = NUM_W'(est3_r) * NUM_W'(hsv2rgb_pkg::HUE_SECTOR);
    diff = num - dp;
    if (diff >= NUM_W'(hsv2rgb_pkg::HUE_SECTOR)) begin
      f4_nxt = est3_r + FRAC_BITS'(1);
    end else begin
      f4_nxt = est3_r;
    end
  end

  // stage 5: 1 - s*f and 1 - s*(1-f)
  always_comb begin
    omf      = ONE - {1'b0, f4_r};
    sf_prod  = (2*W)'(s4_r) * (2*W)'(f4_r);
    s1f_prod = (2*W)'(s4_r) * (2*W)'(omf);
    oq5_nxt  = ONE - sf_prod[FRAC_BITS +: W];
    ot5_nxt  = ONE - s1f_prod[FRAC_BITS +: W];
  end

  // stage 6: q and t; with zero saturation p, q and t all equal v (grey)
  always_comb begin
    q_prod = (2*W)'(v5_r) * (2*W)'(oq5_r);
    t_prod = (2*W)'(v5_r) * (2*W)'(ot5_r);
    q6_nxt = q_prod[FRAC_BITS +: W];
    t6_nxt = t_prod[FRAC_BITS +: W];
  end

  // stage 7: sector mux into the output register
  always_comb begin
    case (sec6_r)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(v6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(t6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(p6_r);
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(q6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(v6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(p6_r);
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(p6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(v6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(t6_r);
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(p6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(q6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(v6_r);
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(t6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(p6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(v6_r);
      end
      default: begin
        red_nxt   = hsv2rgb_pkg::OUT_W'(v6_r);
        green_nxt = hsv2rgb_pkg::OUT_W'(p6_r);
        blue_nxt  = hsv2rgb_pkg::OUT_W'(q6_r);
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // data registers, loaded with their stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1_r <= h1_nxt;
      s1_r <= s1_nxt;
      v1_r <= v1_nxt;
    end
    if (en[1]) begin
      sec2_r <= sec2_nxt;
      rem2_r <= rem2_nxt;
      s2_r   <= s1_r;
      v2_r   <= v1_r;
      p2_r   <= p2_nxt;
    end
    if (en[2]) begin
      est3_r <= est3_nxt;
      rem3_r <= rem2_r;
      sec3_r <= sec2_r;
      s3_r   <= s2_r;
      v3_r   <= v2_r;
      p3_r   <= p2_r;
    end
    if (en[3]) begin
      f4_r   <= f4_nxt;
      sec4_r <= sec3_r;
      s4_r   <= s3_r;
      v4_r   <= v3_r;
      p4_r   <= p3_r;
    end
    if (en[4]) begin
      oq5_r  <= oq5_nxt;
      ot5_r  <= ot5_nxt;
      sec5_r <= sec4_r;
      v5_r   <= v4_r;
      p5_r   <= p4_r;
    end
    if (en[5]) begin
      q6_r   <= q6_nxt;
      t6_r   <= t6_nxt;
      sec6_r <= sec5_r;
      v6_r   <= v5_r;
      p6_r   <= p5_r;
    end
    if (en[6]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // result channel
  assign out_ch.valid     = vld_r[NSTG-1];
  assign out_ch.red_q12   = red_r;
  assign out_ch.green_q12 = green_r;
  assign out_ch.blue_q12  = blue_r;

endmodule

/* tb/sv/tb_hsv_to_rgb_converter_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_hsv_to_rgb_converter_core
// Self-checking bench for the fixed-point HSV to RGB converter.
// ============================================================================
// A queue of HSV requests is filled up front: a directed set covering hue
// wrap and clamp, the sector edges, grey and out-of-range saturation and
// value, then random colors biased toward those corners. A clocked driver
// offers them with random gaps, a clocked receiver takes results with random
// stalls and two long hold-offs, and a monitor predicts every color when its
// request is taken and compares each result with the oldest prediction.
module tb_hsv_to_rgb_converter_core;

  localparam int FRAC       = hsv2rgb_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM   = 950;
  localparam int HOLD_OFF   = 60;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL       = 20;

  typedef struct packed {
    logic signed [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic signed [hsv2rgb_pkg::SV_W-1:0]  sat;
    logic signed [hsv2rgb_pkg::SV_W-1:0]  val;
    logic                                 flush_first;
  } hsv_req_t;

  typedef struct packed {
    logic [hsv2rgb_pkg::OUT_W-1:0] red;
    logic [hsv2rgb_pkg::OUT_W-1:0] green;
    logic [hsv2rgb_pkg::OUT_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;

  hsv_in_if  hsv_bus ();
  rgb_out_if rgb_bus ();

  hsv_to_rgb_converter_core #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (hsv_bus.sink),
    .out_ch(rgb_bus.source)
  );

  hsv_req_t hsv_pending[$];
  rgb_t     rgb_expected[$];
  int       hsv_total = 0;
  int       hsv_taken = 0;
  int       err_count = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp a signed fraction to 0..1
  function automatic longint unit_clamp(longint x);
    if (x < 0) return 0;
    if (x > (longint'(1) << FRAC)) return longint'(1) << FRAC;
    return x;
  endfunction

  // expected color for one hsv request
  function automatic rgb_t hsv_convert(hsv_req_t req);
    longint one, h, s, v, rem, f, p, q, t, r, g, b;
    rgb_t   res;
    one = longint'(1) << FRAC;
    h = longint'($signed(req.hue));
    s = unit_clamp(longint'($signed(req.sat)));
    v = unit_clamp(longint'($signed(req.val)));
    // single wrap by one turn, then clamp
    if (h > hsv2rgb_pkg::HUE_TURN) begin
      h = h - hsv2rgb_pkg::HUE_TURN;
    end else if (h < 0) begin
      h = h + hsv2rgb_pkg::HUE_TURN;
      if (h >= hsv2rgb_pkg::HUE_TURN) h = 0;
    end
    if (h > hsv2rgb_pkg::HUE_MAX) h = hsv2rgb_pkg::HUE_MAX;
    if (h < 0) h = 0;
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      rem = h % hsv2rgb_pkg::HUE_SECTOR;
      f = (rem << FRAC) / hsv2rgb_pkg::HUE_SECTOR;
      p = (v * (one - s)) >> FRAC;
      q = (v * (one - ((s * f) >> FRAC))) >> FRAC;
      t = (v * (one - ((s * (one - f)) >> FRAC))) >> FRAC;
      case (hsv2rgb_pkg::sector_t'(h / hsv2rgb_pkg::HUE_SECTOR))
        hsv2rgb_pkg::SEC_RED_YEL: begin r = v; g = t; b = p; end
        hsv2rgb_pkg::SEC_YEL_GRN: begin r = q; g = v; b = p; end
        hsv2rgb_pkg::SEC_GRN_CYN: begin r = p; g = v; b = t; end
        hsv2rgb_pkg::SEC_CYN_BLU: begin r = p; g = q; b = v; end
        hsv2rgb_pkg::SEC_BLU_MAG: begin r = t; g = p; b = v; end
        default:                  begin r = v; g = p; b = q; end
      endcase
    end
    res.red   = hsv2rgb_pkg::OUT_W'(r);
    res.green = hsv2rgb_pkg::OUT_W'(g);
    res.blue  = hsv2rgb_pkg::OUT_W'(b);
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random saturation or value, biased to zero and full scale
  function automatic logic signed [hsv2rgb_pkg::SV_W-1:0] rand_unit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return '0;
    if (pick < 20) return hsv2rgb_pkg::SV_W'(1 << FRAC);
    if (pick < 30) return hsv2rgb_pkg::SV_W'($urandom());
    return hsv2rgb_pkg::SV_W'($urandom_range(0, 4915) - 410);
  endfunction

  task automatic push_hsv(int hue, int sat, int val, bit flush);
    hsv_req_t req;
    req.hue         = hsv2rgb_pkg::HUE_W'(hue);
    req.sat         = hsv2rgb_pkg::SV_W'(sat);
    req.val         = hsv2rgb_pkg::SV_W'(val);
    req.flush_first = flush;
    hsv_pending.push_back(req);
    hsv_total++;
  endtask

  // request driver
  int hsv_in_flight;
  int tx_gap;
  int tx_calm;
  always @(posedge clk) begin : tx_proc
    hsv_req_t req;
    if (!rst_n) begin
      hsv_bus.valid        <= 1'b0;
      hsv_bus.hue_centideg <= '0;
      hsv_bus.sat_q12      <= '0;
      hsv_bus.val_q12      <= '0;
      hsv_in_flight = 0;
      tx_gap        = 0;
      tx_calm       = 0;
    end else begin
      hsv_in_flight = hsv_in_flight + int'(hsv_bus.valid && hsv_bus.ready)
                      - int'(rgb_bus.valid && rgb_bus.ready);
      if (!hsv_bus.valid || hsv_bus.ready) begin
        if (tx_gap > 0) begin
          hsv_bus.valid <= 1'b0;
          tx_gap = tx_gap - 1;
        end else if (hsv_pending.size() > 0 &&
                     (!hsv_pending[0].flush_first || hsv_in_flight == 0)) begin
          req = hsv_pending.pop_front();
          hsv_bus.valid        <= 1'b1;
          hsv_bus.hue_centideg <= req.hue;
          hsv_bus.sat_q12      <= req.sat;
          hsv_bus.val_q12      <= req.val;
          // gap before the next request, with stretches of back-to-back
          if (tx_calm > 0) begin
            tx_calm = tx_calm - 1;
          end else if ($urandom_range(0, 49) == 0) begin
            tx_calm = $urandom_range(40, 120);
          end else begin
            tx_gap = idle_len();
          end
        end else begin
          hsv_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and two long hold-offs
  int rgb_taken;
  int rx_stall;
  int rx_calm;
  always @(posedge clk) begin : rx_proc
    int gap;
    if (!rst_n) begin
      rgb_bus.ready <= 1'b0;
      rgb_taken = 0;
      rx_stall  = 0;
      rx_calm   = 0;
    end else begin
      if (rgb_bus.valid && rgb_bus.ready) rgb_taken = rgb_taken + 1;
      if (rx_stall > 0) begin
        rgb_bus.ready <= 1'b0;
        rx_stall = rx_stall - 1;
      end else if (!rgb_bus.ready || !rgb_bus.valid) begin
        rgb_bus.ready <= 1'b1;
      end else begin
        if (rgb_taken == 150 || rgb_taken == 600) begin
          gap = HOLD_OFF;
        end else if (rx_calm > 0) begin
          rx_calm = rx_calm - 1;
          gap = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          rx_calm = $urandom_range(40, 120);
          gap = 0;
        end else begin
          gap = idle_len();
        end
        rgb_bus.ready <= (gap == 0);
        if (gap > 0) rx_stall = gap - 1;
      end
    end
  end

  // monitor: check results first, then predict the newly taken request
  always @(posedge clk) begin : mon_proc
    hsv_req_t req;
    rgb_t     got;
    rgb_t     want;
    if (rst_n) begin
      if (rgb_bus.valid && rgb_bus.ready) begin
        got.red   = rgb_bus.red_q12;
        got.green = rgb_bus.green_q12;
        got.blue  = rgb_bus.blue_q12;
        if (rgb_expected.size() == 0) begin
          $display("%0t: unexpected color r=%0d g=%0d b=%0d",
                   $time, got.red, got.green, got.blue);
          err_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
            err_count++;
          end
        end
      end
      if (hsv_bus.valid && hsv_bus.ready) begin
        req.hue         = hsv_bus.hue_centideg;
        req.sat         = hsv_bus.sat_q12;
        req.val         = hsv_bus.val_q12;
        req.flush_first = 1'b0;
        rgb_expected.push_back(hsv_convert(req));
        hsv_taken++;
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((hsv_bus.valid && hsv_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d colors still expected", $time, rgb_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : main_proc
    int hue;
    int pick;
    rst_n = 1'b0;

    // hue wrap and clamp, sector edges, grey and out-of-range corners
    push_hsv(-100,   4096, 4096, 1'b0);
    push_hsv(0,      4096, 4096, 1'b0);
    push_hsv(36099,  2048, 3000, 1'b0);
    push_hsv(36000,  4096, 4096, 1'b0);
    push_hsv(35999,  4096, 2000, 1'b0);
    push_hsv(-1,     4096, 4096, 1'b0);
    push_hsv(5999,   4096, 4096, 1'b0);
    push_hsv(6000,   3000, 4096, 1'b0);
    push_hsv(12000,  4096, 4096, 1'b0);
    push_hsv(18000,  4096, 3500, 1'b0);
    push_hsv(24000,  2500, 4096, 1'b0);
    push_hsv(30000,  4096, 4096, 1'b0);
    push_hsv(35990,  4096, 4096, 1'b0);
    push_hsv(-65536, 8191, 8191, 1'b0);
    push_hsv(65535, -8192, 4096, 1'b0);
    push_hsv(9000,   0,    2500, 1'b0);
    push_hsv(15000,  4505, 4505, 1'b0);
    push_hsv(21000, -410, -410,  1'b0);
    push_hsv(27000,  1,    4096, 1'b0);
    push_hsv(33000,  4095, 1,    1'b0);
    push_hsv(3000,   4096, 0,    1'b0);
    push_hsv(-36000, 4096, 4096, 1'b0);
    push_hsv(36001,  4096, 4096, 1'b0);
    push_hsv(1,      8191, -1,   1'b0);

    // random colors; the sender drains the pipeline before the first and midway
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        hue = int'($signed(hsv2rgb_pkg::HUE_W'($urandom())));
      end else if (pick < 35) begin
        hue = hsv2rgb_pkg::HUE_SECTOR * $urandom_range(0, hsv2rgb_pkg::HUE_NSEC)
              + $urandom_range(0, 4) - 2;
      end else begin
        hue = $urandom_range(0, 36199) - 100;
      end
      push_hsv(hue, int'($signed(rand_unit())), int'($signed(rand_unit())),
               i == 0 || i == N_RANDOM / 2);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (hsv_taken < hsv_total || rgb_expected.size() > 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
